FILE: design/cmos_rtc_pkg.sv
// cmos_rtc_pkg: shared types, codes, register addresses and bcd helpers
// for the cmos rtc time registers block; no dependencies
package cmos_rtc_pkg;

   localparam int CmdWidth  = 2;
   localparam int AddrWidth = 8;
   localparam int DataWidth = 8;
   localparam int CsrIndexWidth = 2;
   localparam int CsrDataWidth  = 16;

   typedef logic [CmdWidth-1:0]  cmd_type;
   typedef logic [AddrWidth-1:0] addr_type;
   typedef logic [DataWidth-1:0] data_type;

   // command codes
   localparam cmd_type CMD_TICK  = 2'd0;
   localparam cmd_type CMD_READ  = 2'd1;
   localparam cmd_type CMD_WRITE = 2'd2;

   // bus register addresses
   localparam addr_type ADDR_SECONDS = 8'h00;
   localparam addr_type ADDR_MINUTES = 8'h02;
   localparam addr_type ADDR_HOURS   = 8'h04;
   localparam addr_type ADDR_STATUS  = 8'h0A;
   localparam addr_type ADDR_FORMAT  = 8'h0B;

   // configuration register indexes
   localparam logic [CsrIndexWidth-1:0] CSR_BINARY_MODE = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_MODE_24_HOUR = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_TICKS_PER_SECOND = 2'd2;

   localparam logic [15:0] TICKS_PER_SECOND_RESET = 16'd18;

   localparam data_type PM_FLAG   = 8'h80;
   localparam data_type HOUR_MASK = 8'h7F;
   localparam data_type MAX_SECOND = 8'd59;
   localparam data_type MAX_MINUTE = 8'd59;
   localparam data_type MAX_HOUR   = 8'd23;
   localparam data_type NOON       = 8'd12;

   // binary to packed bcd, quotient by reciprocal multiply (exact below 1029)
   function automatic data_type bin_to_bcd(input data_type v);
      logic [15:0] prod;
      logic [4:0]  quot;
      data_type    rem;
      prod = {8'd0, v} * 16'd205;
      quot = prod[15:11];
      rem  = v - ({3'd0, quot} * 8'd10);
      return {quot[3:0], rem[3:0]};
   endfunction

   // packed bcd to binary, non-decimal nibbles weighted as is
   function automatic data_type bcd_to_bin(input data_type d);
      data_type hi;
      hi = {4'd0, d[7:4]};
      return {4'd0, d[3:0]} + (hi << 3) + (hi << 1);
   endfunction

endpackage

FILE: design/cmos_rtc_req_if.sv
// cmos_rtc_req_if: request channel (valid, ready, command word)
// depends on cmos_rtc_pkg
interface cmos_rtc_req_if;
   logic                  valid;
   logic                  ready;
   cmos_rtc_pkg::cmd_type  cmd;
   cmos_rtc_pkg::addr_type reg_addr;
   cmos_rtc_pkg::data_type write_data;

   modport source (output valid, output cmd, output reg_addr, output write_data,
                   input ready);
   modport sink   (input valid, input cmd, input reg_addr, input write_data,
                   output ready);
endinterface

FILE: design/cmos_rtc_rsp_if.sv
// cmos_rtc_rsp_if: response channel (valid, ready, read data word)
// depends on cmos_rtc_pkg
interface cmos_rtc_rsp_if;
   logic                  valid;
   logic                  ready;
   cmos_rtc_pkg::data_type read_data;

   modport source (output valid, output read_data, input ready);
   modport sink   (input valid, input read_data, output ready);
endinterface

FILE: design/cmos_rtc_time_registers_unit.sv
// cmos_rtc_time_registers_unit: rtc time keeping with bcd/binary and 12/24 hour bus view
// depends on cmos_rtc_pkg, cmos_rtc_req_if, cmos_rtc_rsp_if
//
//   channel | direction | word                            | handshake
//   req_ch  | in        | cmd, reg_addr, write_data       | valid/ready
//   rsp_ch  | out       | read_data (reads only)          | valid/ready
//   csr_*   | in        | write_en, index, write_data     | write_en only
//
// two register stages: a request register, then the execute step that
// updates the time state and loads the response register
// one word per cycle unless a stalled response holds the pipe; a read answer leaves from the response register
// synchronous active-high reset clears valids, time state and format bits
// a stalled response holds the execute step; req ready drops only when the
// request register is full and cannot move on
module cmos_rtc_time_registers_unit (
   input  logic                                        clock,
   input  logic                                        reset,
   cmos_rtc_req_if.sink                                req_ch,
   cmos_rtc_rsp_if.source                              rsp_ch,
   input  logic                                        csr_write_en,
   input  logic [cmos_rtc_pkg::CsrIndexWidth-1:0]      csr_index,
   input  logic [cmos_rtc_pkg::CsrDataWidth-1:0]       csr_write_data
);

   // configuration
   logic        binary_mode_ff;
   logic        mode_24_hour_ff;
   logic [15:0] ticks_per_second_ff;

   // request register
   logic                   req_valid_ff;
   cmos_rtc_pkg::cmd_type  req_cmd_ff;
   cmos_rtc_pkg::addr_type req_addr_ff;
   cmos_rtc_pkg::data_type req_data_ff;

   // time state
   logic [15:0]            tick_count_ff, tick_count_in;
   cmos_rtc_pkg::data_type seconds_ff, seconds_in;
   cmos_rtc_pkg::data_type minutes_ff, minutes_in;
   cmos_rtc_pkg::data_type hours_ff, hours_in;

   // response register
   logic                   rsp_valid_ff, rsp_valid_in;
   cmos_rtc_pkg::data_type rsp_data_ff, rsp_data_in;

   logic                   rsp_free;
   logic                   exec;
   logic                   time_in_range;
   logic [16:0]            tick_next;
   cmos_rtc_pkg::data_type enc_hours;
   cmos_rtc_pkg::data_type hour12;
   cmos_rtc_pkg::data_type dec_field;
   cmos_rtc_pkg::data_type dec_hours;
   cmos_rtc_pkg::data_type dec_hour_raw;
   cmos_rtc_pkg::data_type sec_inc, min_inc, hour_inc;

   assign rsp_free = !rsp_valid_ff || rsp_ch.ready;
   assign exec     = req_valid_ff && rsp_free;
   assign req_ch.ready = !req_valid_ff || rsp_free;

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.read_data = rsp_data_ff;

   assign time_in_range = (hours_ff <= cmos_rtc_pkg::MAX_HOUR) &&
                          (minutes_ff <= cmos_rtc_pkg::MAX_MINUTE) &&
                          (seconds_ff <= cmos_rtc_pkg::MAX_SECOND);

   // hours as seen on the bus
   always_comb begin
      hour12 = hours_ff;
      if (hours_ff >= cmos_rtc_pkg::NOON) begin
         hour12 = hours_ff - cmos_rtc_pkg::NOON;
      end
      if (hour12 == 8'd0) begin
         hour12 = cmos_rtc_pkg::NOON;
      end
      if (mode_24_hour_ff || (hours_ff > cmos_rtc_pkg::MAX_HOUR)) begin
         enc_hours = binary_mode_ff ? hours_ff : cmos_rtc_pkg::bin_to_bcd(hours_ff);
      end else begin
         enc_hours = (binary_mode_ff ? hour12 : cmos_rtc_pkg::bin_to_bcd(hour12)) |
                     ((hours_ff >= cmos_rtc_pkg::NOON) ? cmos_rtc_pkg::PM_FLAG : 8'd0);
      end
   end

   // written byte decoded into binary
   always_comb begin
      dec_field = binary_mode_ff ? req_data_ff : cmos_rtc_pkg::bcd_to_bin(req_data_ff);
      dec_hour_raw = binary_mode_ff ? (req_data_ff & cmos_rtc_pkg::HOUR_MASK)
                   : cmos_rtc_pkg::bcd_to_bin(req_data_ff & cmos_rtc_pkg::HOUR_MASK);
      if (dec_hour_raw == cmos_rtc_pkg::NOON) begin
         dec_hour_raw = 8'd0;
      end
      if (req_data_ff[7]) begin
         dec_hour_raw = dec_hour_raw + cmos_rtc_pkg::NOON;
      end
      dec_hours = mode_24_hour_ff ? dec_field : dec_hour_raw;
   end

   // one-second advance with wraps, only from an in-range time
   always_comb begin
      sec_inc  = seconds_ff + 8'd1;
      min_inc  = minutes_ff;
      hour_inc = hours_ff;
      if (sec_inc > cmos_rtc_pkg::MAX_SECOND) begin
         sec_inc = 8'd0;
         min_inc = minutes_ff + 8'd1;
      end
      if (min_inc > cmos_rtc_pkg::MAX_MINUTE) begin
         min_inc  = 8'd0;
         hour_inc = hours_ff + 8'd1;
      end
      if (hour_inc > cmos_rtc_pkg::MAX_HOUR) begin
         hour_inc = 8'd0;
      end
   end

   assign tick_next = {1'b0, tick_count_ff} + 17'd1;

   // execute step
   always_comb begin
      tick_count_in = tick_count_ff;
      seconds_in    = seconds_ff;
      minutes_in    = minutes_ff;
      hours_in      = hours_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      if (exec) begin
         case (req_cmd_ff)
            cmos_rtc_pkg::CMD_TICK: begin
               if (tick_next >= {1'b0, ticks_per_second_ff}) begin
                  tick_count_in = 16'd0;
                  if (time_in_range) begin
                     seconds_in = sec_inc;
                     minutes_in = min_inc;
                     hours_in   = hour_inc;
                  end
               end else begin
                  tick_count_in = tick_next[15:0];
               end
            end
            cmos_rtc_pkg::CMD_READ: begin
               rsp_valid_in = 1'b1;
               unique case (req_addr_ff)
                  cmos_rtc_pkg::ADDR_SECONDS: rsp_data_in = binary_mode_ff ? seconds_ff
                                               : cmos_rtc_pkg::bin_to_bcd(seconds_ff);
                  cmos_rtc_pkg::ADDR_MINUTES: rsp_data_in = binary_mode_ff ? minutes_ff
                                               : cmos_rtc_pkg::bin_to_bcd(minutes_ff);
                  cmos_rtc_pkg::ADDR_HOURS:   rsp_data_in = enc_hours;
                  cmos_rtc_pkg::ADDR_FORMAT:  rsp_data_in = {5'd0, binary_mode_ff,
                                                             mode_24_hour_ff, 1'b0};
                  // status reads zero: updates are atomic
                  default:                    rsp_data_in = 8'd0;
               endcase
            end
            cmos_rtc_pkg::CMD_WRITE: begin
               unique case (req_addr_ff)
                  cmos_rtc_pkg::ADDR_SECONDS: seconds_in = dec_field;
                  cmos_rtc_pkg::ADDR_MINUTES: minutes_in = dec_field;
                  cmos_rtc_pkg::ADDR_HOURS:   hours_in   = dec_hours;
                  default: ;
               endcase
            end
            default: ;
         endcase
      end
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff        <= 1'b0;
         rsp_valid_ff        <= 1'b0;
         tick_count_ff       <= 16'd0;
         seconds_ff          <= 8'd0;
         minutes_ff          <= 8'd0;
         hours_ff            <= 8'd0;
         binary_mode_ff      <= 1'b0;
         mode_24_hour_ff     <= 1'b0;
         ticks_per_second_ff <= cmos_rtc_pkg::TICKS_PER_SECOND_RESET;
      end else begin
         if (req_ch.ready) begin
            req_valid_ff <= req_ch.valid;
         end
         rsp_valid_ff  <= rsp_valid_in;
         tick_count_ff <= tick_count_in;
         seconds_ff    <= seconds_in;
         minutes_ff    <= minutes_in;
         hours_ff      <= hours_in;
         if (csr_write_en) begin
            unique case (csr_index)
               cmos_rtc_pkg::CSR_BINARY_MODE:      binary_mode_ff <= csr_write_data[0];
               cmos_rtc_pkg::CSR_MODE_24_HOUR:     mode_24_hour_ff <= csr_write_data[0];
               cmos_rtc_pkg::CSR_TICKS_PER_SECOND: ticks_per_second_ff <= csr_write_data;
               default: ;
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_ch.ready && req_ch.valid) begin
         req_cmd_ff  <= req_ch.cmd;
         req_addr_ff <= req_ch.reg_addr;
         req_data_ff <= req_ch.write_data;
      end
      rsp_data_ff <= rsp_data_in;
   end

`ifndef SYNTHESIS
   // a response appears only after a read was executed
   a_rsp_from_read: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(exec && (req_cmd_ff == cmos_rtc_pkg::CMD_READ)))
      else $error("response without an executed read");

   // ticks and reads keep an in-range time in range
   a_time_stays_valid: assert property (@(posedge clock) disable iff (reset)
      ($past(exec) && $past(req_cmd_ff != cmos_rtc_pkg::CMD_WRITE) &&
       $past(time_in_range)) |-> time_in_range)
      else $error("time left its valid range");

   // after a tick the prescaler sits below the rate or at zero
   a_prescaler_bound: assert property (@(posedge clock) disable iff (reset)
      ($past(exec && (req_cmd_ff == cmos_rtc_pkg::CMD_TICK)) && !$past(csr_write_en))
      |-> (tick_count_ff == 16'd0 || tick_count_ff < ticks_per_second_ff))
      else $error("prescaler beyond ticks per second");

   // request side stalls only behind a blocked response
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> (req_valid_ff && rsp_valid_ff && !rsp_ch.ready))
      else $error("request stalled without a blocked response");
`endif

endmodule

FILE: test/cmos_rtc_time_registers_unit_tb.sv
// cmos_rtc_time_registers_unit_tb: self-checking bench for the rtc time registers block,
// with a shadow copy of the clock state that predicts every bus read
// depends on cmos_rtc_pkg, cmos_rtc_req_if, cmos_rtc_rsp_if, cmos_rtc_time_registers_unit

class rtc_time_scoreboard;
   bit                     binary_mode;
   bit                     mode_24_hour;
   logic [15:0]            ticks_per_second;
   logic [15:0]            tick_count;
   cmos_rtc_pkg::data_type seconds;
   cmos_rtc_pkg::data_type minutes;
   cmos_rtc_pkg::data_type hours;
   cmos_rtc_pkg::data_type expected_reads[$];
   int                     errors;

   function new();
      binary_mode      = 1'b0;
      mode_24_hour     = 1'b0;
      ticks_per_second = cmos_rtc_pkg::TICKS_PER_SECOND_RESET;
      tick_count       = '0;
      seconds          = '0;
      minutes          = '0;
      hours            = '0;
      errors           = 0;
   endfunction

   // values above 99 keep only the low byte of the packed digits
   function cmos_rtc_pkg::data_type to_bcd(input cmos_rtc_pkg::data_type v);
      logic [15:0] packed_digits;
      packed_digits = ({8'd0, v} / 16'd10) << 4;
      packed_digits = packed_digits | ({8'd0, v} % 16'd10);
      return packed_digits[7:0];
   endfunction

   function cmos_rtc_pkg::data_type from_bcd(input cmos_rtc_pkg::data_type d);
      return cmos_rtc_pkg::data_type'(d[3:0]) + cmos_rtc_pkg::data_type'(d[7:4]) * 8'd10;
   endfunction

   function cmos_rtc_pkg::data_type encode_field(input cmos_rtc_pkg::data_type v);
      return binary_mode ? v : to_bcd(v);
   endfunction

   function cmos_rtc_pkg::data_type decode_field(input cmos_rtc_pkg::data_type d);
      return binary_mode ? d : from_bcd(d);
   endfunction

   function cmos_rtc_pkg::data_type encode_hours(input cmos_rtc_pkg::data_type h);
      cmos_rtc_pkg::data_type shown;
      cmos_rtc_pkg::data_type pm;
      shown = h;
      pm    = '0;
      if (!mode_24_hour && h <= cmos_rtc_pkg::MAX_HOUR) begin
         if (h >= cmos_rtc_pkg::NOON) begin
            pm    = cmos_rtc_pkg::PM_FLAG;
            shown = h - cmos_rtc_pkg::NOON;
         end
         if (shown == 8'd0)
            shown = cmos_rtc_pkg::NOON;
      end
      return encode_field(shown) | pm;
   endfunction

   function cmos_rtc_pkg::data_type decode_hours(input cmos_rtc_pkg::data_type d);
      cmos_rtc_pkg::data_type v;
      if (mode_24_hour)
         return decode_field(d);
      v = decode_field(d & cmos_rtc_pkg::HOUR_MASK);
      if (v == cmos_rtc_pkg::NOON)
         v = 8'd0;
      if ((d & cmos_rtc_pkg::PM_FLAG) != 8'd0)
         v = v + cmos_rtc_pkg::NOON;
      return v;
   endfunction

   function void set_register(input logic [cmos_rtc_pkg::CsrIndexWidth-1:0] idx,
                              input logic [cmos_rtc_pkg::CsrDataWidth-1:0] value);
      case (idx)
         cmos_rtc_pkg::CSR_BINARY_MODE:      binary_mode = value[0];
         cmos_rtc_pkg::CSR_MODE_24_HOUR:     mode_24_hour = value[0];
         cmos_rtc_pkg::CSR_TICKS_PER_SECOND: ticks_per_second = value;
         default: ;
      endcase
   endfunction

   function void advance_second();
      if (hours > cmos_rtc_pkg::MAX_HOUR || minutes > cmos_rtc_pkg::MAX_MINUTE ||
          seconds > cmos_rtc_pkg::MAX_SECOND)
         return;
      seconds = seconds + 8'd1;
      if (seconds > cmos_rtc_pkg::MAX_SECOND) begin
         seconds = '0;
         minutes = minutes + 8'd1;
      end
      if (minutes > cmos_rtc_pkg::MAX_MINUTE) begin
         minutes = '0;
         hours   = hours + 8'd1;
      end
      if (hours > cmos_rtc_pkg::MAX_HOUR)
         hours = '0;
   endfunction

   function void note_request(input cmos_rtc_pkg::cmd_type c, input cmos_rtc_pkg::addr_type a,
                              input cmos_rtc_pkg::data_type d);
      int unsigned            next_count;
      cmos_rtc_pkg::data_type value;
      case (c)
         cmos_rtc_pkg::CMD_TICK: begin
            next_count = tick_count + 1;
            if (next_count >= ticks_per_second) begin
               tick_count = '0;
               advance_second();
            end else begin
               tick_count = next_count[15:0];
            end
         end
         cmos_rtc_pkg::CMD_READ: begin
            value = '0;
            case (a)
               cmos_rtc_pkg::ADDR_SECONDS: value = encode_field(seconds);
               cmos_rtc_pkg::ADDR_MINUTES: value = encode_field(minutes);
               cmos_rtc_pkg::ADDR_HOURS:   value = encode_hours(hours);
               cmos_rtc_pkg::ADDR_FORMAT:  value = {5'd0, binary_mode, mode_24_hour, 1'b0};
               default: ;
            endcase
            expected_reads.push_back(value);
         end
         cmos_rtc_pkg::CMD_WRITE: begin
            case (a)
               cmos_rtc_pkg::ADDR_SECONDS: seconds = decode_field(d);
               cmos_rtc_pkg::ADDR_MINUTES: minutes = decode_field(d);
               cmos_rtc_pkg::ADDR_HOURS:   hours = decode_hours(d);
               default: ;
            endcase
         end
         default: ;
      endcase
   endfunction

   function void check_read(input cmos_rtc_pkg::data_type actual, input realtime stamp);
      cmos_rtc_pkg::data_type wanted;
      if (expected_reads.size() == 0) begin
         $display("[%0.1f ns] unexpected read word: expected none, actual 8'h%02h",
                  stamp, actual);
         errors++;
         return;
      end
      wanted = expected_reads.pop_front();
      if (actual !== wanted) begin
         $display("[%0.1f ns] read_data mismatch: expected 8'h%02h, actual 8'h%02h",
                  stamp, wanted, actual);
         errors++;
      end
   endfunction
endclass

module cmos_rtc_time_registers_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // command 3 has no meaning in the block and must be dropped
   localparam cmos_rtc_pkg::cmd_type CMD_UNUSED = 2'd3;
   localparam cmos_rtc_pkg::addr_type BUS_REGS [5] = '{cmos_rtc_pkg::ADDR_SECONDS,
                                                       cmos_rtc_pkg::ADDR_MINUTES,
                                                       cmos_rtc_pkg::ADDR_HOURS,
                                                       cmos_rtc_pkg::ADDR_STATUS,
                                                       cmos_rtc_pkg::ADDR_FORMAT};
   // settling time after the last read word: two pipeline stages plus margin
   localparam int SETTLE_CYCLES = 6;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                                   csr_write_en;
   logic [cmos_rtc_pkg::CsrIndexWidth-1:0] csr_index;
   logic [cmos_rtc_pkg::CsrDataWidth-1:0]  csr_write_data;

   cmos_rtc_req_if req_ch ();
   cmos_rtc_rsp_if rsp_ch ();

   cmos_rtc_time_registers_unit i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_ch),
      .rsp_ch         (rsp_ch),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   rtc_time_scoreboard rtc_shadow = new();

   // idle percentages for the current phase, read by the driver and the receiver
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   // words that reach the time logic, ignored commands are not counted
   int words_sent    = 0;

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // hard limit well above the slowest legal run
   initial begin
      #5_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   // receiver side: random stalls on the response channel
   always @(posedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // sample both handshakes and the csr port at the edge, before any update lands
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready)
            rtc_shadow.check_read(rsp_ch.read_data, $realtime);
         if (req_ch.valid && req_ch.ready)
            rtc_shadow.note_request(req_ch.cmd, req_ch.reg_addr, req_ch.write_data);
         if (csr_write_en)
            rtc_shadow.set_register(csr_index, csr_write_data);
      end
   end

   // one word on the request channel; valid is left high so back-to-back words
   // follow without a gap, the caller lowers it when the stream pauses
   task automatic send_word(input cmos_rtc_pkg::cmd_type c, input cmos_rtc_pkg::addr_type a,
                            input cmos_rtc_pkg::data_type d);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.cmd        <= c;
      req_ch.reg_addr   <= a;
      req_ch.write_data <= d;
      @(posedge clock);
      while (!req_ch.ready)
         @(posedge clock);
      if (!(c == CMD_UNUSED ||
            (c == cmos_rtc_pkg::CMD_WRITE && a != cmos_rtc_pkg::ADDR_SECONDS &&
             a != cmos_rtc_pkg::ADDR_MINUTES && a != cmos_rtc_pkg::ADDR_HOURS)))
         words_sent++;
   endtask

   // stop sending and wait until every read is answered and the pipe is empty
   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (rtc_shadow.expected_reads.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // write enable stays high for back-to-back writes, the caller lowers it
   task automatic write_csr(input logic [cmos_rtc_pkg::CsrIndexWidth-1:0] idx,
                            input logic [cmos_rtc_pkg::CsrDataWidth-1:0] value);
      csr_write_en   <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= value;
      @(posedge clock);
   endtask

   // new clock format, only written with the block idle
   task automatic set_format(input bit bin, input bit h24, input logic [15:0] tps);
      drain();
      write_csr(cmos_rtc_pkg::CSR_BINARY_MODE, {15'd0, bin});
      write_csr(cmos_rtc_pkg::CSR_MODE_24_HOUR, {15'd0, h24});
      write_csr(cmos_rtc_pkg::CSR_TICKS_PER_SECOND, tps);
      csr_write_en <= 1'b0;
   endtask

   function automatic cmos_rtc_pkg::data_type rand_byte();
      return cmos_rtc_pkg::data_type'($urandom_range(255));
   endfunction

   task automatic tick_word();
      send_word(cmos_rtc_pkg::CMD_TICK, cmos_rtc_pkg::addr_type'($urandom_range(255)),
                rand_byte());
   endtask

   task automatic read_time();
      send_word(cmos_rtc_pkg::CMD_READ, cmos_rtc_pkg::ADDR_SECONDS, rand_byte());
      send_word(cmos_rtc_pkg::CMD_READ, cmos_rtc_pkg::ADDR_MINUTES, rand_byte());
      send_word(cmos_rtc_pkg::CMD_READ, cmos_rtc_pkg::ADDR_HOURS, rand_byte());
   endtask

   // mostly well-formed time sets with ticks and read-back, plus noise
   // and out-of-range writes that freeze the clock
   task automatic run_random_words(input int target);
      int                     first;
      int                     pick;
      cmos_rtc_pkg::data_type sec;
      cmos_rtc_pkg::data_type mins;
      cmos_rtc_pkg::data_type hr;
      cmos_rtc_pkg::addr_type a;
      first = words_sent;
      while (words_sent - first < target) begin
         pick = $urandom_range(99);
         if (pick < 60) begin
            // bias toward the rollover corners so wraps happen often
            if ($urandom_range(3) != 0) begin
               sec  = $urandom_range(1) ? cmos_rtc_pkg::data_type'(50 + $urandom_range(9))
                                        : cmos_rtc_pkg::data_type'($urandom_range(59));
               mins = $urandom_range(1) ? cmos_rtc_pkg::data_type'(57 + $urandom_range(2))
                                        : cmos_rtc_pkg::data_type'($urandom_range(59));
               hr   = $urandom_range(1) ? cmos_rtc_pkg::data_type'(11 + 11 * $urandom_range(1)
                                                                   + $urandom_range(1))
                                        : cmos_rtc_pkg::data_type'($urandom_range(23));
               send_word(cmos_rtc_pkg::CMD_WRITE, cmos_rtc_pkg::ADDR_SECONDS,
                         rtc_shadow.encode_field(sec));
               send_word(cmos_rtc_pkg::CMD_WRITE, cmos_rtc_pkg::ADDR_MINUTES,
                         rtc_shadow.encode_field(mins));
               send_word(cmos_rtc_pkg::CMD_WRITE, cmos_rtc_pkg::ADDR_HOURS,
                         rtc_shadow.encode_hours(hr));
            end
            repeat ($urandom_range(12, 1)) tick_word();
            read_time();
            if ($urandom_range(7) == 0)
               send_word(cmos_rtc_pkg::CMD_READ, cmos_rtc_pkg::ADDR_FORMAT, rand_byte());
         end else if (pick < 80) begin
            a = $urandom_range(1) ? cmos_rtc_pkg::addr_type'($urandom_range(255))
                                  : BUS_REGS[$urandom_range(4)];
            send_word(cmos_rtc_pkg::cmd_type'($urandom_range(3)), a, rand_byte());
         end else begin
            a = BUS_REGS[$urandom_range(2)];
            send_word(cmos_rtc_pkg::CMD_WRITE, a, rand_byte());
            repeat ($urandom_range(4, 1)) tick_word();
            send_word(cmos_rtc_pkg::CMD_READ, a, rand_byte());
         end
      end
   endtask

   initial begin
      req_ch.valid      = 1'b0;
      req_ch.cmd        = cmos_rtc_pkg::CMD_TICK;
      req_ch.reg_addr   = '0;
      req_ch.write_data = '0;
      csr_write_en      = 1'b0;
      csr_index         = cmos_rtc_pkg::CSR_BINARY_MODE;
      csr_write_data    = '0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset format: bcd, 12-hour; midnight reads as 12 am
      send_word(cmos_rtc_pkg::CMD_READ, cmos_rtc_pkg::ADDR_FORMAT, 8'h00);
      send_word(cmos_rtc_pkg::CMD_READ, cmos_rtc_pkg::ADDR_STATUS, 8'h00);
      send_word(cmos_rtc_pkg::CMD_READ, cmos_rtc_pkg::ADDR_HOURS, 8'h00);
      // 12 pm is noon, 1 pm is 13
      send_word(cmos_rtc_pkg::CMD_WRITE, cmos_rtc_pkg::ADDR_HOURS, 8'h92);
      send_word(cmos_rtc_pkg::CMD_READ, cmos_rtc_pkg::ADDR_HOURS, 8'hFF);
      send_word(cmos_rtc_pkg::CMD_WRITE, cmos_rtc_pkg::ADDR_HOURS, 8'h81);
      send_word(cmos_rtc_pkg::CMD_READ, cmos_rtc_pkg::ADDR_HOURS, 8'hFF);
      // unused command and writes to status/format are dropped
      send_word(CMD_UNUSED, cmos_rtc_pkg::ADDR_HOURS, 8'h00);
      send_word(cmos_rtc_pkg::CMD_WRITE, cmos_rtc_pkg::ADDR_FORMAT, 8'hFF);
      send_word(cmos_rtc_pkg::CMD_WRITE, cmos_rtc_pkg::ADDR_STATUS, 8'hFF);
      send_word(cmos_rtc_pkg::CMD_READ, cmos_rtc_pkg::ADDR_FORMAT, 8'h00);
      send_word(cmos_rtc_pkg::CMD_READ, 8'hFF, 8'h00);

      // binary 24-hour, one tick per second: full-day rollover
      set_format(1'b1, 1'b1, 16'd1);
      send_word(cmos_rtc_pkg::CMD_WRITE, cmos_rtc_pkg::ADDR_SECONDS, 8'd59);
      send_word(cmos_rtc_pkg::CMD_WRITE, cmos_rtc_pkg::ADDR_MINUTES, 8'd59);
      send_word(cmos_rtc_pkg::CMD_WRITE, cmos_rtc_pkg::ADDR_HOURS, 8'd23);
      tick_word();
      read_time();
      // out-of-range hour freezes the clock
      send_word(cmos_rtc_pkg::CMD_WRITE, cmos_rtc_pkg::ADDR_HOURS, 8'hFF);
      tick_word();
      send_word(cmos_rtc_pkg::CMD_READ, cmos_rtc_pkg::ADDR_HOURS, 8'h00);
      send_word(cmos_rtc_pkg::CMD_READ, cmos_rtc_pkg::ADDR_SECONDS, 8'h00);
      send_word(cmos_rtc_pkg::CMD_WRITE, cmos_rtc_pkg::ADDR_HOURS, 8'd5);

      // slowest rate, then lowered below the running count: next tick advances
      set_format(1'b1, 1'b1, 16'hFFFF);
      repeat (3) tick_word();
      set_format(1'b1, 1'b1, 16'd2);
      tick_word();
      send_word(cmos_rtc_pkg::CMD_READ, cmos_rtc_pkg::ADDR_SECONDS, 8'h00);
      // zero rate advances on every tick
      set_format(1'b1, 1'b1, 16'd0);
      tick_word();
      send_word(cmos_rtc_pkg::CMD_READ, cmos_rtc_pkg::ADDR_SECONDS, 8'h00);

      // random phases: every format, rate extremes, and each idling pattern
      set_format(1'b0, 1'b0, 16'd1);
      send_idle_pct = 0;  rsp_stall_pct = 0;
      run_random_words(225);
      set_format(1'b1, 1'b0, 16'd2);
      send_idle_pct = 57; rsp_stall_pct = 0;
      run_random_words(225);
      set_format(1'b0, 1'b1, 16'd3);
      send_idle_pct = 0;  rsp_stall_pct = 57;
      run_random_words(225);
      set_format(1'b1, 1'b1, 16'd1);
      send_idle_pct = 15; rsp_stall_pct = 15;
      run_random_words(225);
      set_format(1'b0, 1'b0, 16'hFFFF);
      send_idle_pct = 0;  rsp_stall_pct = 0;
      run_random_words(225);
      set_format(1'b1, 1'b1, cmos_rtc_pkg::TICKS_PER_SECOND_RESET);
      send_idle_pct = 57; rsp_stall_pct = 0;
      run_random_words(225);
      set_format(1'b0, 1'b1, 16'd0);
      send_idle_pct = 0;  rsp_stall_pct = 57;
      run_random_words(225);
      set_format(1'b1, 1'b0, 16'd1);
      send_idle_pct = 15; rsp_stall_pct = 15;
      run_random_words(225);

      // let the last reads come back, then keep watching for stray words
      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (rtc_shadow.errors == 0 && rtc_shadow.expected_reads.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
